// ===== rtl/deq_pkg.sv =====
// Shared constants and types for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

    // Number of words the ring can hold.
    localparam int DEPTH = 64;

    // Ring index width and count width (the count must reach DEPTH itself).
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Widths of the item fields.
    localparam int REQ_W       = 4;
    localparam int WORD_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int ENTRY_CNT_W = 7;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE     = 4'd0,
        REQ_DESTROY    = 4'd1,
        REQ_CLEAR      = 4'd2,
        REQ_PUSH_FRONT = 4'd3,
        REQ_PUSH_BACK  = 4'd4,
        REQ_POP_FRONT  = 4'd5,
        REQ_POP_BACK   = 4'd6,
        REQ_PEEK_FRONT = 4'd7,
        REQ_PEEK_BACK  = 4'd8
    } t_req;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_NOT_CREATED = 3'd2,
        ST_FULL        = 3'd3,
        ST_ALREADY     = 3'd4
    } t_status;

endpackage

// ===== rtl/deq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/double_ended_queue.sv =====
// Top level of the bounded double-ended queue of signed 32-bit words.
`timescale 1ns / 1ps

// The queue keeps its words in a ring held in one RAM with a registered
// read, plus front index, count and created flag in registers.
// Create, destroy, clear, push and unknown requests complete at their accept
// edge; a push writes the RAM at the edge it is accepted. Pop and peek pass
// through the read register of the RAM: the word is read at the accept edge
// and lands in the result register in the cycle after, and no new item is
// taken while that read is pending. The result sits in an output register,
// so a new item is taken in the same cycle the previous result is taken. The
// word store needs no clearing after reset; the block accepts items from the first cycle after reset is released.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [REQ_W-1:0]              i_req_type,
    input  logic signed [WORD_W-1:0]      i_value_in,
    // Result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [STATUS_W-1:0]           o_status,
    output logic signed [WORD_W-1:0]      o_value_out,
    output logic [ENTRY_CNT_W-1:0]        o_entry_count,
    output logic                          o_is_empty
);

    localparam int SUM_W = CNT_W + 1;

    // Queue state.
    logic [ADDR_W-1:0]   r_front, n_front;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_created, n_created;

    // Read in flight and result register.
    logic                r_pend;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [WORD_W-1:0]   r_out_value;
    logic [CNT_W-1:0]    r_out_count;

    // Request decode outputs.
    logic                accept;
    logic                is_read;
    t_status             status;
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    // Ring position of the word at a given distance from the front.
    function automatic logic [ADDR_W-1:0] ring_pos(input logic [ADDR_W-1:0] front,
                                                    input logic [CNT_W-1:0]  offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(front) + SUM_W'(offset);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    assign o_ready = !r_pend && (!r_out_valid || i_ready);
    assign accept  = i_valid && o_ready;

    // Decode the request into the next queue state and a RAM access.
    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        n_created = r_created;
        status    = ST_OK;
        is_read   = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_front;
        ram_raddr = r_front;

        if (i_req_type == REQ_CREATE) begin
            if (r_created) begin
                status = ST_ALREADY;
            end else begin
                n_created = 1'b1;
                n_front   = '0;
                n_count   = '0;
            end
        end else if (i_req_type <= REQ_PEEK_BACK && !r_created) begin
            status = ST_NOT_CREATED;
        end else begin
            unique case (i_req_type) inside
                REQ_DESTROY: begin
                    n_front   = '0;
                    n_count   = '0;
                    n_created = 1'b0;
                end
                REQ_CLEAR: begin
                    n_front = '0;
                    n_count = '0;
                end
                REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                    if (r_count >= CNT_W'(DEPTH)) begin
                        status = ST_FULL;
                    end else if (i_req_type == REQ_PUSH_FRONT) begin
                        n_front   = (r_front == '0) ? ADDR_W'(DEPTH - 1)
                                                    : r_front - 1'b1;
                        ram_we    = 1'b1;
                        ram_waddr = n_front;
                        n_count   = r_count + 1'b1;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = ring_pos(r_front, r_count);
                        n_count   = r_count + 1'b1;
                    end
                end
                REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
                    if (r_count == '0) begin
                        status = ST_EMPTY;
                    end else begin
                        is_read = 1'b1;
                        ram_re  = 1'b1;
                        if (i_req_type == REQ_POP_FRONT || i_req_type == REQ_PEEK_FRONT) begin
                            ram_raddr = r_front;
                            if (i_req_type == REQ_POP_FRONT) begin
                                n_front = ring_pos(r_front, CNT_W'(1));
                                n_count = r_count - 1'b1;
                            end
                        end else begin
                            ram_raddr = ring_pos(r_front, r_count - 1'b1);
                            if (i_req_type == REQ_POP_BACK) begin
                                n_count = r_count - 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // Only an accepted item touches the RAM.
        ram_we = ram_we && accept;
        ram_re = ram_re && accept;
    end

    // Word store.
    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value_in),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Queue state and control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_created   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_front     <= n_front;
                r_count     <= n_count;
                r_created   <= n_created;
                r_pend      <= is_read;
                r_out_valid <= !is_read;
            end else if (r_pend) begin
                r_pend      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; a read fills in the word in the cycle after accept.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_status <= status;
            r_out_value  <= '0;
            r_out_count  <= n_count;
        end else if (r_pend) begin
            r_out_value  <= ram_rdata;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_value_out   = r_out_value;
    assign o_entry_count = ENTRY_CNT_W'(r_out_count);
    assign o_is_empty    = (r_out_count == '0);

    // A pending read always finds the result register free.
    a_pend_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend && r_out_valid))
        else $error("read pending while result register is full");

    // The count never exceeds the ring size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // A queue that does not exist holds no words.
    a_uncreated_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_created |-> (r_count == '0))
        else $error("words held while queue not created");

    // A read item holds o_valid low while its read is pending and raises it in the cycle after that.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_read) |=> (r_pend && !o_valid) ##1 o_valid)
        else $error("read result not delivered on time");

endmodule
